/* src/dcmf_pkg.sv */
`timescale 1ns / 1ps
package dcmf_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_WIDTH_W = 11;
	localparam int CFG_HEIGHT_W = 11;
	localparam int CFG_RADIUS_W = 4;
	localparam int CFG_MODE_W = 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_RADIUS = 8;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd3;

	localparam logic [CFG_WIDTH_W-1:0] RST_WIDTH = 11'd1024;
	localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 11'd1024;
	localparam logic [CFG_RADIUS_W-1:0] RST_RADIUS = 4'd1;
	localparam logic [CFG_MODE_W-1:0] RST_MODE = 1'b1;

	localparam logic [CFG_MODE_W-1:0] MODE_GRAY = 1'b0;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic emit;
		logic last;
	} ctl_t;

	function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (b < a) ? b : a;
	endfunction

endpackage

/* src/dark_channel_min_filter_core.sv */
`timescale 1ns / 1ps
// Pipeline: a result leaves the output register after the item that causes it passes the
//   column buffer read, the column minimum and the row window into the output register.
// Throughput: one item per unstalled cycle, set by the single buffer read-modify-write.
// Reset: arst_n clears counters, pipeline valids and configuration to its defaults; the
//   column buffer is not cleared, entries from rows above the frame are masked instead.
module dark_channel_min_filter_core #(
	parameter int MAX_WIDTH = dcmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dcmf_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = dcmf_pkg::DEF_MAX_RADIUS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dcmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcmf_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel channel
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  logic [dcmf_pkg::PIX_W-1:0]      red_or_gray,
	input  logic [dcmf_pkg::PIX_W-1:0]      green,
	input  logic [dcmf_pkg::PIX_W-1:0]      blue,
	// result channel
	output logic                           dark_valid,
	input  logic                           dark_stall,
	output logic [dcmf_pkg::PIX_W-1:0]      dark_value,
	output logic                           last_of_frame
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ORW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int RCW = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);
	localparam int RDW = $clog2(MAX_RADIUS + 1);
	localparam int NCW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

	logic [dcmf_pkg::CFG_WIDTH_W-1:0]  width_q;
	logic [dcmf_pkg::CFG_HEIGHT_W-1:0] height_q;
	logic [dcmf_pkg::CFG_RADIUS_W-1:0] radius_q;
	logic [dcmf_pkg::CFG_MODE_W-1:0]   mode_q;

	logic [WCW-1:0] w;
	logic [HCW-1:0] h;
	logic [RDW-1:0] r;
	logic [NCW-1:0] total;
	logic [NCW-1:0] lag;

	logic [NCW-1:0] n_q, n_cur;
	logic [AW-1:0]  cn_q, cn_cur;
	logic [RCW-1:0] rn_q, rn_cur;
	logic [AW-1:0]  oc_q, oc_cur;
	logic [ORW-1:0] or_q, or_cur;
	logic           restart;
	logic           emit_cur;
	logic           last_cur;
	logic           acc;
	logic           adv;
	logic [dcmf_pkg::PIX_W-1:0] pm;
	dcmf_pkg::ctl_t ctl_cur;

	logic                       valid_s2;
	logic [dcmf_pkg::PIX_W-1:0] vmin_s2;
	logic [AW-1:0]              oc_s2;
	dcmf_pkg::ctl_t             ctl_s2;

	// registers are always writable; user writes must come only while the block is idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= dcmf_pkg::RST_WIDTH;
			height_q <= dcmf_pkg::RST_HEIGHT;
			radius_q <= dcmf_pkg::RST_RADIUS;
			mode_q <= dcmf_pkg::RST_MODE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dcmf_pkg::REG_WIDTH:  width_q <= cfg_data[dcmf_pkg::CFG_WIDTH_W-1:0];
				dcmf_pkg::REG_HEIGHT: height_q <= cfg_data[dcmf_pkg::CFG_HEIGHT_W-1:0];
				dcmf_pkg::REG_RADIUS: radius_q <= cfg_data[dcmf_pkg::CFG_RADIUS_W-1:0];
				dcmf_pkg::REG_MODE:   mode_q <= cfg_data[dcmf_pkg::CFG_MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate the registers into their meaningful ranges
	always_comb begin
		if (width_q == '0)
			w = WCW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w = WCW'(MAX_WIDTH);
		else
			w = WCW'(width_q);
		if (height_q == '0)
			h = HCW'(1);
		else if (32'(height_q) > MAX_HEIGHT)
			h = HCW'(MAX_HEIGHT);
		else
			h = HCW'(height_q);
		if (32'(radius_q) > MAX_RADIUS)
			r = RDW'(MAX_RADIUS);
		else
			r = RDW'(radius_q);
	end

	assign total = NCW'(w) * NCW'(h);
	assign lag = NCW'(r) * NCW'(w) + NCW'(r);

	// the pipeline moves whenever the output register is free or being drained
	assign adv = !dark_valid || !dark_stall;
	assign pix_stall = !adv;
	assign acc = pix_valid && !pix_stall;

	// a frame left over by a size change starts over at pixel 0
	assign restart = (n_q >= total + lag);
	assign n_cur = restart ? '0 : n_q;
	assign cn_cur = restart ? '0 : cn_q;
	assign rn_cur = restart ? '0 : rn_q;
	assign oc_cur = restart ? '0 : oc_q;
	assign or_cur = restart ? '0 : or_q;
	assign emit_cur = (n_cur >= lag);
	assign last_cur = emit_cur && (WCW'(oc_cur) == w - WCW'(1)) &&
		(HCW'(or_cur) == h - HCW'(1));
	assign ctl_cur = '{emit: emit_cur, last: last_cur};

	always_comb begin
		pm = red_or_gray;
		if (mode_q != dcmf_pkg::MODE_GRAY)
			pm = dcmf_pkg::min2(dcmf_pkg::min2(red_or_gray, green), blue);
	end

	// raster position of the incoming item and of the output it completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			cn_q <= '0;
			rn_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (acc) begin
			if (last_cur) begin
				n_q <= '0;
				cn_q <= '0;
				rn_q <= '0;
				oc_q <= '0;
				or_q <= '0;
			end else begin
				n_q <= n_cur + NCW'(1);
				if (WCW'(cn_cur) == w - WCW'(1)) begin
					cn_q <= '0;
					rn_q <= rn_cur + RCW'(1);
				end else begin
					cn_q <= cn_cur + AW'(1);
					rn_q <= rn_cur;
				end
				if (emit_cur) begin
					if (WCW'(oc_cur) == w - WCW'(1)) begin
						oc_q <= '0;
						or_q <= or_cur + ORW'(1);
					end else begin
						oc_q <= oc_cur + AW'(1);
						or_q <= or_cur;
					end
				end else begin
					oc_q <= oc_cur;
					or_q <= or_cur;
				end
			end
		end
	end

	// column minimum over the vertical window, buffer keeps the last rows of each column
	dcmf_vert #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS),
		.RCW(RCW),
		.HCW(HCW),
		.OCW(AW)
	) u_vert (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.acc(acc),
		.pm(pm),
		.col(cn_cur),
		.row(rn_cur),
		.oc(oc_cur),
		.ctl(ctl_cur),
		.radius(r),
		.height(h),
		.valid_s2(valid_s2),
		.vmin_s2(vmin_s2),
		.oc_s2(oc_s2),
		.ctl_s2(ctl_s2)
	);

	// row window over the column minima, clipped to the current row
	dcmf_horz #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS),
		.OCW(AW),
		.WCW(WCW)
	) u_horz (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_in(valid_s2),
		.vmin(vmin_s2),
		.oc(oc_s2),
		.ctl(ctl_s2),
		.radius(r),
		.width(w),
		.out_valid(dark_valid),
		.dark_value(dark_value),
		.last_of_frame(last_of_frame)
	);

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_cur |=> (n_q == '0) && (oc_q == '0) && (or_q == '0))
		else $error("counters not cleared after last pixel of frame");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !last_cur |=> n_q == $past(n_cur) + NCW'(1))
		else $error("item counter skipped");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> dark_valid && dark_stall)
		else $error("input stalled with output register free");

endmodule

/* src/dcmf_ram.sv */
`timescale 1ns / 1ps
module dcmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* src/dcmf_vert.sv */
`timescale 1ns / 1ps
module dcmf_vert #(
	parameter int MAX_WIDTH = dcmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = dcmf_pkg::DEF_MAX_RADIUS,
	parameter int RCW = 11,
	parameter int HCW = 11,
	parameter int OCW = 10,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int NT = 2 * MAX_RADIUS + 1,
	localparam int ENT_W = dcmf_pkg::PIX_W * 2 * MAX_RADIUS,
	localparam int RDW = $clog2(MAX_RADIUS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      acc,
	input  logic [dcmf_pkg::PIX_W-1:0] pm,
	input  logic [AW-1:0]             col,
	input  logic [RCW-1:0]            row,
	input  logic [OCW-1:0]            oc,
	input  dcmf_pkg::ctl_t            ctl,
	input  logic [RDW-1:0]            radius,
	input  logic [HCW-1:0]            height,
	output logic                      valid_s2,
	output logic [dcmf_pkg::PIX_W-1:0] vmin_s2,
	output logic [OCW-1:0]            oc_s2,
	output dcmf_pkg::ctl_t            ctl_s2
);

	localparam int CW2 = RCW + 1;
	localparam int NP = 1 << $clog2(NT);

	logic                       valid_s1;
	logic [dcmf_pkg::PIX_W-1:0] pm_s1;
	logic [AW-1:0]              col_s1;
	logic [RCW-1:0]             row_s1;
	logic [OCW-1:0]             oc_s1;
	dcmf_pkg::ctl_t             ctl_s1;
	logic                       fwd_sel_q;
	logic [ENT_W-1:0]           fwd_data_q;
	logic [ENT_W-1:0]           rdata;
	logic [ENT_W-1:0]           entry;
	logic [ENT_W-1:0]           new_entry;
	logic [dcmf_pkg::PIX_W-1:0] vals [NT];
	logic [dcmf_pkg::PIX_W-1:0] masked [NT];
	logic [dcmf_pkg::PIX_W-1:0] masked_s2 [NT];
	logic [dcmf_pkg::PIX_W-1:0] tr [1:2*NP-1];

	dcmf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WIDTH)) u_ram (
		.clk(clk),
		.re(acc),
		.raddr(col),
		.rdata(rdata),
		.we(adv && valid_s1),
		.waddr(col_s1),
		.wdata(new_entry)
	);

	// the write of the item in s1 lands at the same edge the next read is taken
	assign entry = fwd_sel_q ? fwd_data_q : rdata;
	assign new_entry = {entry[ENT_W-dcmf_pkg::PIX_W-1:0], pm_s1};

	always_comb begin
		vals[0] = pm_s1;
		for (int j = 1; j < NT; j++)
			vals[j] = entry[dcmf_pkg::PIX_W*(j-1) +: dcmf_pkg::PIX_W];
		for (int j = 0; j < NT; j++) begin
			if ((CW2'(j) <= (CW2'(radius) << 1)) && (CW2'(j) <= CW2'(row_s1)) &&
			    (CW2'(row_s1) + CW2'(1) <= CW2'(height) + CW2'(j)))
				masked[j] = vals[j];
			else
				masked[j] = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fwd_sel_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
			if (acc)
				fwd_sel_q <= valid_s1 && (col_s1 == col);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				pm_s1 <= pm;
				col_s1 <= col;
				row_s1 <= row;
				oc_s1 <= oc;
				ctl_s1 <= ctl;
				fwd_data_q <= new_entry;
			end
			masked_s2 <= masked;
			oc_s2 <= oc_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < NP; i++)
			tr[NP+i] = (i < NT) ? masked_s2[i] : '1;
		for (int i = NP - 1; i >= 1; i--)
			tr[i] = dcmf_pkg::min2(tr[2*i], tr[2*i+1]);
	end

	assign vmin_s2 = tr[1];

endmodule

/* src/dcmf_horz.sv */
`timescale 1ns / 1ps
module dcmf_horz #(
	parameter int MAX_WIDTH = dcmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = dcmf_pkg::DEF_MAX_RADIUS,
	parameter int OCW = 10,
	parameter int WCW = 11,
	localparam int NT = 2 * MAX_RADIUS + 1,
	localparam int RDW = $clog2(MAX_RADIUS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      valid_in,
	input  logic [dcmf_pkg::PIX_W-1:0] vmin,
	input  logic [OCW-1:0]            oc,
	input  dcmf_pkg::ctl_t            ctl,
	input  logic [RDW-1:0]            radius,
	input  logic [WCW-1:0]            width,
	output logic                      out_valid,
	output logic [dcmf_pkg::PIX_W-1:0] dark_value,
	output logic                      last_of_frame
);

	localparam int CW2 = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + 2) + 1;
	localparam int NP = 1 << $clog2(NT);

	logic [dcmf_pkg::PIX_W-1:0] taps_q [NT];
	logic                       valid_s3;
	logic [OCW-1:0]             oc_s3;
	dcmf_pkg::ctl_t             ctl_s3;
	logic [dcmf_pkg::PIX_W-1:0] tr [1:2*NP-1];

	// tap 0 is the newest column minimum, the center sits radius taps back
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			if ((i < NT) && (CW2'(i) <= (CW2'(radius) << 1)) &&
			    (CW2'(i) <= CW2'(oc_s3) + CW2'(radius)) &&
			    (CW2'(oc_s3) + CW2'(radius) + CW2'(1) <= CW2'(width) + CW2'(i)))
				tr[NP+i] = taps_q[i];
			else
				tr[NP+i] = '1;
		end
		for (int i = NP - 1; i >= 1; i--)
			tr[i] = dcmf_pkg::min2(tr[2*i], tr[2*i+1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_in;
			out_valid <= valid_s3 && ctl_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_in) begin
				taps_q[0] <= vmin;
				for (int t = 1; t < NT; t++)
					taps_q[t] <= taps_q[t-1];
			end
			oc_s3 <= oc;
			ctl_s3 <= ctl;
			if (valid_s3 && ctl_s3.emit) begin
				dark_value <= tr[1];
				last_of_frame <= ctl_s3.last;
			end
		end
	end

endmodule

/* tb/tb_dark_channel_min_filter_core.sv */
`timescale 1ns / 1ps
module tb_dark_channel_min_filter_core;
	import dcmf_pkg::*;

	localparam int RING_DEPTH = (2 * DEF_MAX_RADIUS + 1) * DEF_MAX_WIDTH;
	localparam int CYCLE_LIMIT = 600000;

	// Windowed channel-minimum predictor plus the queue of dark pixels it still owes.
	class dark_scoreboard;
		logic [CFG_WIDTH_W-1:0] width_reg;
		logic [CFG_HEIGHT_W-1:0] height_reg;
		logic [CFG_RADIUS_W-1:0] radius_reg;
		logic [CFG_MODE_W-1:0] mode_reg;
		logic [PIX_W-1:0] ring[RING_DEPTH];
		int unsigned frame_pos;
		logic [PIX_W:0] owed[$];
		int errors;

		function new();
			width_reg = RST_WIDTH;
			height_reg = RST_HEIGHT;
			radius_reg = RST_RADIUS;
			mode_reg = RST_MODE;
			frame_pos = 0;
			errors = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WIDTH: width_reg = data[CFG_WIDTH_W-1:0];
				REG_HEIGHT: height_reg = data[CFG_HEIGHT_W-1:0];
				REG_RADIUS: radius_reg = data[CFG_RADIUS_W-1:0];
				REG_MODE: mode_reg = data[CFG_MODE_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b);
			int unsigned w, h, rad, total, lag, n, k, row, col, y0, y1, x0, x1;
			logic [PIX_W-1:0] pm, best;
			w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
			h = (height_reg == 0) ? 1 :
				(height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
			rad = (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius_reg;
			total = w * h;
			lag = rad * w + rad;
			if (frame_pos >= total + lag)
				frame_pos = 0;
			n = frame_pos;
			pm = r;
			if (mode_reg != MODE_GRAY) begin
				if (g < pm) pm = g;
				if (b < pm) pm = b;
			end
			ring[n % RING_DEPTH] = pm;
			frame_pos = n + 1;
			if (n < lag)
				return;
			k = n - lag;
			row = k / w;
			col = k % w;
			y0 = (row >= rad) ? row - rad : 0;
			y1 = (row + rad >= h) ? h - 1 : row + rad;
			x0 = (col >= rad) ? col - rad : 0;
			x1 = (col + rad >= w) ? w - 1 : col + rad;
			best = '1;
			for (int unsigned y = y0; y <= y1; y++)
				for (int unsigned x = x0; x <= x1; x++)
					if (ring[(y * w + x) % RING_DEPTH] < best)
						best = ring[(y * w + x) % RING_DEPTH];
			if (k + 1 == total) begin
				owed.push_back({1'b1, best});
				frame_pos = 0;
			end else begin
				owed.push_back({1'b0, best});
			end
		endfunction

		function void check_result(logic [PIX_W-1:0] value, logic last);
			logic [PIX_W:0] exp_item;
			if (owed.size() == 0) begin
				$display("%0t unexpected dark pixel: expected none actual value %0d last %0b",
					$time, value, last);
				errors++;
				return;
			end
			exp_item = owed.pop_front();
			if (value !== exp_item[PIX_W-1:0]) begin
				$display("%0t dark_value mismatch: expected %0d actual %0d",
					$time, exp_item[PIX_W-1:0], value);
				errors++;
			end
			if (last !== exp_item[PIX_W]) begin
				$display("%0t last_of_frame mismatch: expected %0b actual %0b",
					$time, exp_item[PIX_W], last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic pix_valid;
	logic pix_stall;
	logic [PIX_W-1:0] red_or_gray;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic dark_valid;
	logic dark_stall;
	logic [PIX_W-1:0] dark_value;
	logic last_of_frame;

	dark_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int rand_pixels;
	int cycles;

	dark_channel_min_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.red_or_gray(red_or_gray),
		.green(green),
		.blue(blue),
		.dark_valid(dark_valid),
		.dark_stall(dark_stall),
		.dark_value(dark_value),
		.last_of_frame(last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake must not run forever.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: a long hold-off takes priority over the random stall pattern.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			dark_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			dark_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Check every result transfer against the oldest owed dark pixel.
	always @(posedge clk) begin
		if (arst_n && dark_valid && !dark_stall)
			sb.check_result(dark_value, last_of_frame);
	end

	// Mostly random bytes, with the extremes showing up often.
	function automatic logic [PIX_W-1:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one pixel, with random idle gaps first; return once it has transferred.
	task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		red_or_gray <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (pix_stall);
		sb.note_pixel(r, g, b);
	endtask

	// Drain owed results, then give the pipeline its latency before touching registers.
	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// One whole frame: program the registers, stream W*H pixels, then the advance items.
	// pause_at >= 0 holds the sender at that pixel until every owed result is out.
	task automatic run_frame(int w, int h, int rad, int mode, int pause_at, bit rand_part);
		int ew, eh, er, n_adv;
		ew = (w == 0) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
		eh = (h == 0) ? 1 : (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
		er = (rad > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : rad;
		n_adv = er * ew + er;
		wait_idle();
		cfg_write(REG_WIDTH, CFG_DATA_W'(w));
		cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
		cfg_write(REG_RADIUS, CFG_DATA_W'(rad));
		cfg_write(REG_MODE, CFG_DATA_W'(mode));
		for (int i = 0; i < ew * eh; i++) begin
			if (i == pause_at) begin
				pix_valid <= 1'b0;
				while (sb.owed.size() != 0) @(posedge clk);
			end
			send_pixel(pick_byte(), pick_byte(), pick_byte());
			if (rand_part)
				rand_pixels++;
		end
		// advance items: content ignored, still randomized
		for (int i = 0; i < n_adv; i++) begin
			send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
			if (rand_part)
				rand_pixels++;
		end
		pix_valid <= 1'b0;
	endtask

	task automatic set_phase(int idx);
		case (idx % 4)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 60; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 60; end
			default: begin send_idle_pct = 33; recv_stall_pct = 33; end
		endcase
	endtask

	initial begin
		int frame_idx;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		rand_pixels = 0;
		frame_idx = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_valid = 1'b0;
		red_or_gray = '0;
		green = '0;
		blue = '0;
		dark_stall = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: small color and gray frames, zero radius, clipped windows.
		run_frame(3, 3, 1, 1, -1, 0);
		run_frame(4, 2, 0, 0, -1, 0);
		run_frame(0, 5, 2, 0, -1, 0);
		run_frame(2, 2, 8, 1, -1, 0);

		// Extremes, including out-of-range values that saturate.
		set_phase(3);
		run_frame(5, 2, 15, 1, -1, 0);
		run_frame(1, 0, 8, 0, -1, 0);
		run_frame(3, 0, 0, 1, -1, 0);

		// Pressure: long receiver hold-off fills the block, then a sender pause mid-frame.
		set_phase(0);
		hold_left = 300;
		run_frame(20, 6, 2, 1, 60, 0);

		// Random frames, cycling through the idle/stall phases.
		while (rand_pixels < 460) begin
			set_phase(frame_idx);
			frame_idx++;
			run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 9),
				$urandom_range(0, 1), ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : -1,
				1);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
